@@ rtl/assert_macros.svh @@
// Assertion macros used by the pool allocator head.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is held.
`define FBPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// Same-cycle implication built on the plain check.
`define FBPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    `FBPA_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication built on the plain check.
`define FBPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    `FBPA_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

@@ rtl/fbpa_pkg.sv @@
// Types, constants and codes of the fixed block pool allocator.
package fbpa_pkg;

    // Pool storage
    localparam int POOL_DEPTH = 64;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CMP_W      = (IDX_W > 7) ? IDX_W : 7;
    localparam logic [IDX_W-1:0] LAST_K = IDX_W'(POOL_DEPTH - 1);

    // Field widths
    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 16;
    localparam int CNT_W     = 7;
    localparam int CIDX_W    = 6;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 64;

    // Register map
    localparam int PADDR_W = 4;
    localparam logic [PADDR_W-1:0] ADDR_BASE  = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_SIZE  = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_COUNT = 4'h8;
    localparam logic [SIZE_W-1:0]  SIZE_RESET = 16'd32;

    typedef enum logic [1:0] {
        CMD_ALLOC       = 2'd0,
        CMD_FREE        = 2'd1,
        CMD_SET_BLOCKED = 2'd2,
        CMD_GET_STATE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_FREE        = 2'd0,
        ST_USED        = 2'd1,
        ST_BLOCKED     = 2'd2,
        ST_NOT_HANDLED = 2'd3
    } t_slot_state;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_RUN  = 1'b1
    } t_fsm;

    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic [SIZE_W-1:0] item_size;
        logic [CNT_W-1:0]  chunk_count;
    } t_cfg;

    // Control of the ring of state cells
    typedef struct packed {
        logic        shift;
        t_slot_state din;
    } t_ring_ctl;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] chunk_address;
        logic [CIDX_W-1:0] chunk_index;
        t_slot_state       query_state;
        logic [CNT_W-1:0]  used_count;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  blocked_count;
    } t_result;

endpackage

@@ rtl/fbpa_regs.sv @@
// APB configuration registers of the pool allocator.
module fbpa_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output fbpa_pkg::t_cfg              o_cfg
);
    import fbpa_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address <= '0;
            r_cfg.item_size    <= SIZE_RESET;
            r_cfg.chunk_count  <= '0;
        end else if (wr_en) begin
            case (paddr)
                ADDR_BASE:  r_cfg.base_address <= pwdata;
                ADDR_SIZE:  r_cfg.item_size    <= pwdata[SIZE_W-1:0];
                ADDR_COUNT: r_cfg.chunk_count  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (paddr)
            ADDR_BASE:  prdata = r_cfg.base_address;
            ADDR_SIZE:  prdata = {{(32-SIZE_W){1'b0}}, r_cfg.item_size};
            ADDR_COUNT: prdata = {{(32-CNT_W){1'b0}}, r_cfg.chunk_count};
            default:    prdata = '0;
        endcase
    end

endmodule

@@ rtl/fbpa_cell.sv @@
// One chunk state cell of the circulating ring.
module fbpa_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  fbpa_pkg::t_slot_state i_d,
    output fbpa_pkg::t_slot_state o_q
);
    import fbpa_pkg::*;

    t_slot_state r_q;

    assign o_q = r_q;

    // Take the neighbour's state on a shift, else hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= ST_FREE;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

endmodule

@@ rtl/fbpa_head.sv @@
// Processing head: walks the ring one chunk a cycle unless a waiting result stalls it, and builds the result.
module fbpa_head (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fbpa_pkg::t_cfg               i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  fbpa_pkg::t_cmd               i_cmd,
    input  logic [fbpa_pkg::ADDR_W-1:0]  i_address,
    input  logic [fbpa_pkg::CIDX_W-1:0]  i_index,
    input  logic                         i_block_flag,
    input  fbpa_pkg::t_slot_state        i_cell,
    output fbpa_pkg::t_ring_ctl          o_ring,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output fbpa_pkg::t_result            o_res
);
    import fbpa_pkg::*;
    `include "assert_macros.svh"

    t_fsm              r_fsm, n_fsm;
    logic [IDX_W-1:0]  r_k;
    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [CIDX_W-1:0] r_idx;
    logic              r_flag;
    logic [ADDR_W-1:0] r_run_addr;
    logic              r_found, n_found;
    logic [ADDR_W-1:0] r_caddr, n_caddr;
    logic [CIDX_W-1:0] r_cidx, n_cidx;
    t_slot_state       r_cstate, n_cstate;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [CNT_W-1:0]  r_free, n_free;
    logic [CNT_W-1:0]  r_blocked, n_blocked;
    logic              r_out_valid;
    t_result           r_res;

    t_slot_state       ns;
    logic              active, hit_idx, last, out_can, take, load_res;
    logic [CMP_W+1:0]  walk_total;

    assign last     = (r_k == LAST_K);
    assign out_can  = !r_out_valid || i_out_ready;
    assign take     = (r_fsm == FSM_IDLE) && i_in_valid;
    assign load_res = (r_fsm == FSM_RUN) && last && out_can;

    // Next state
    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            FSM_IDLE: if (i_in_valid) n_fsm = FSM_RUN;
            FSM_RUN:  if (last && out_can) n_fsm = FSM_IDLE;
            default:  n_fsm = FSM_IDLE;
        endcase
    end

    // Handshake and ring control
    always_comb begin
        o_in_ready   = 1'b0;
        o_ring.shift = 1'b0;
        o_ring.din   = ns;
        case (r_fsm)
            FSM_IDLE: o_in_ready = 1'b1;
            FSM_RUN:  o_ring.shift = !last || out_can;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= FSM_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    // Decision for the chunk now at the head of the ring
    always_comb begin
        active   = CMP_W'(r_k) < CMP_W'(i_cfg.chunk_count);
        hit_idx  = CMP_W'(r_k) == CMP_W'(r_idx);
        ns       = i_cell;
        n_found  = r_found;
        n_caddr  = r_caddr;
        n_cidx   = r_cidx;
        n_cstate = r_cstate;
        case (r_cmd)
            CMD_ALLOC: begin
                if (active && !r_found && i_cell == ST_FREE) begin
                    ns      = ST_USED;
                    n_found = 1'b1;
                    n_caddr = r_run_addr;
                    n_cidx  = CIDX_W'(r_k);
                end
            end
            CMD_FREE: begin
                if (r_addr != '0 && active && !r_found && r_run_addr == r_addr) begin
                    ns      = ST_FREE;
                    n_found = 1'b1;
                    n_caddr = r_addr;
                    n_cidx  = CIDX_W'(r_k);
                end
            end
            CMD_SET_BLOCKED: begin
                if (active && hit_idx && i_cell != ST_USED) begin
                    ns      = r_flag ? ST_BLOCKED : ST_FREE;
                    n_found = 1'b1;
                end
            end
            CMD_GET_STATE: begin
                if (active && hit_idx) begin
                    n_cstate = i_cell;
                    n_found  = 1'b1;
                end
            end
            default: ;
        endcase

        // counts taken over the state left behind
        n_used    = r_used;
        n_free    = r_free;
        n_blocked = r_blocked;
        if (active) begin
            case (ns)
                ST_USED:    n_used    = r_used + 1'b1;
                ST_FREE:    n_free    = r_free + 1'b1;
                ST_BLOCKED: n_blocked = r_blocked + 1'b1;
                default: ;
            endcase
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_k        <= '0;
            r_cmd      <= i_cmd;
            r_addr     <= i_address;
            r_idx      <= i_index;
            r_flag     <= i_block_flag;
            r_run_addr <= i_cfg.base_address;
            r_found    <= 1'b0;
            r_caddr    <= '0;
            r_cidx     <= (i_cmd == CMD_SET_BLOCKED || i_cmd == CMD_GET_STATE) ?
                          i_index : '0;
            r_cstate   <= (i_cmd == CMD_GET_STATE) ? ST_NOT_HANDLED : ST_FREE;
            r_used     <= '0;
            r_free     <= '0;
            r_blocked  <= '0;
        end else if (o_ring.shift) begin
            r_k        <= r_k + 1'b1;
            r_run_addr <= r_run_addr + {{(ADDR_W-SIZE_W){1'b0}}, i_cfg.item_size};
            r_found    <= n_found;
            r_caddr    <= n_caddr;
            r_cidx     <= n_cidx;
            r_cstate   <= n_cstate;
            r_used     <= n_used;
            r_free     <= n_free;
            r_blocked  <= n_blocked;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_res) begin
            r_res.ok            <= n_found;
            r_res.chunk_address <= n_caddr;
            r_res.chunk_index   <= n_cidx;
            r_res.query_state   <= n_cstate;
            r_res.used_count    <= n_used;
            r_res.free_count    <= n_free;
            r_res.blocked_count <= n_blocked;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    // chunks counted so far in the walk
    assign walk_total = {2'b00, CMP_W'(r_used)} + {2'b00, CMP_W'(r_free)} +
                        {2'b00, CMP_W'(r_blocked)};

    // Checks
    `FBPA_ASSERT_NXT(a_found_sticks, i_clk, i_rst_n, (r_fsm == FSM_RUN) && r_found, r_found)
    `FBPA_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, r_fsm == FSM_RUN,
                     walk_total <= {2'b00, CMP_W'(r_k)})
    `FBPA_ASSERT_IMP(a_not_handled_fails, i_clk, i_rst_n,
                     r_out_valid && (r_res.query_state == ST_NOT_HANDLED), !r_res.ok)
    `FBPA_ASSERT_IMP(a_stall_holds_ring, i_clk, i_rst_n,
                     r_out_valid && !i_out_ready && last, !o_ring.shift)

endmodule

@@ rtl/fixed_block_pool_allocator.sv @@
// Top level of the fixed block pool allocator: registers, state ring and head.
//
//  channel   direction  ports                    content
//  s         in         i_s_tvalid/o_s_tready    one command item
//  m         out        o_m_tvalid/i_m_tready    one result item per command
//  apb       in/out     psel..pready             base, item size, chunk count
//
// An item is accepted, then handled chunk by chunk while the chunk states
// circulate once round the ring of cells past the head.
// The result sits in an output register; a new item is accepted while it waits.
// A result still not taken holds the head on the last chunk of the next item.
// Synchronous reset marks every chunk free.
module fixed_block_pool_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // s_tdata: address[31:0], index[37:32], block_flag[38], zero[39]
    input  logic [fbpa_pkg::IN_DATA_W-1:0] i_s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [1:0]                  i_s_tuser,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // m_tdata: ok[0], chunk_address[32:1], chunk_index[38:33], query_state[40:39],
    //          used_count[47:41], free_count[54:48], blocked_count[61:55], zero[63:62]
    output logic [fbpa_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import fbpa_pkg::*;

    t_cfg        cfg;
    t_ring_ctl   ring;
    t_result     res;
    t_slot_state cell_q [POOL_DEPTH];

    fbpa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Ring of state cells; cell 0 feeds the head, the head feeds the last cell
    for (genvar j = 0; j < POOL_DEPTH; j++) begin : g_cell
        if (j == POOL_DEPTH - 1) begin : g_tail
            fbpa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (ring.shift),
                .i_d     (ring.din),
                .o_q     (cell_q[j])
            );
        end else begin : g_body
            fbpa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (ring.shift),
                .i_d     (cell_q[j+1]),
                .o_q     (cell_q[j])
            );
        end
    end

    fbpa_head u_head (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_cmd        (t_cmd'(i_s_tuser)),
        .i_address    (i_s_tdata[ADDR_W-1:0]),
        .i_index      (i_s_tdata[ADDR_W+CIDX_W-1:ADDR_W]),
        .i_block_flag (i_s_tdata[ADDR_W+CIDX_W]),
        .i_cell       (cell_q[0]),
        .o_ring       (ring),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_res        (res)
    );

    // Result packing, lowest field first
    assign o_m_tdata = {2'b00, res.blocked_count, res.free_count, res.used_count,
                        res.query_state, res.chunk_index, res.chunk_address, res.ok};

endmodule
